[rtl/chbd_pkg.sv]
// package for the chunked body decoder: types, character codes and defaults
// no dependencies; imported by every module of the block
`default_nettype none

package chbd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned MAX_BODY_W     = 24;
  localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 24'd1048576;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_DCR,
    PH_DLF,
    PH_TRAILER,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic rearmed;
    logic finished;
  } status_t;

endpackage

`default_nettype wire

[rtl/chbd_front.sv]
// front end: accepts raw body words and classifies each byte
// depends on chbd_pkg; feeds chbd_queue
`default_nettype none

module chbd_front
  import chbd_pkg::*;
(
  input  wire logic       s_valid_i,
  input  wire logic [7:0] s_data_i,
  input  wire logic       s_eos_i,
  output logic            s_ready_o,
  input  wire logic       q_full_i,
  output logic            push_o,
  output item_t           item_o
);

  logic is_digit;
  logic is_alpha;

  always_comb begin
    is_digit = (s_data_i >= 8'h30) && (s_data_i <= 8'h39);
    is_alpha = ((s_data_i >= 8'h61) && (s_data_i <= 8'h66)) ||
               ((s_data_i >= 8'h41) && (s_data_i <= 8'h46));
    item_o.eos     = s_eos_i;
    item_o.data    = s_data_i;
    item_o.is_cr   = (s_data_i == CHAR_CR);
    item_o.is_lf   = (s_data_i == CHAR_LF);
    item_o.is_semi = (s_data_i == CHAR_SEMI);
    item_o.is_hex  = is_digit | is_alpha;
    item_o.hex_val = is_digit ? s_data_i[3:0] : (s_data_i[3:0] + 4'd9);
  end

  assign s_ready_o = ~q_full_i;
  assign push_o    = s_valid_i & ~q_full_i;

endmodule

`default_nettype wire

[rtl/chbd_queue.sv]
// short register queue of classified words between front and back
// depends on chbd_pkg
`default_nettype none

module chbd_queue
  import chbd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  item_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/chbd_back.sv]
// back end: chunk framing state machine and output register
// depends on chbd_pkg; takes classified words from chbd_queue
`default_nettype none

module chbd_back
  import chbd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [MAX_BODY_W-1:0] max_body_i,
  input  wire logic                  q_valid_i,
  input  wire item_t                 item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  output logic [7:0]                 out_data_o,
  output logic [1:0]                 out_kind_o,
  input  wire logic                  out_ready_i,
  output status_t                    status_o
);

  localparam int unsigned CW = (COUNT_BITS + 1 > MAX_BODY_W + 1) ? COUNT_BITS + 1
                                                                 : MAX_BODY_W + 1;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] chunk_q, chunk_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  saw_q, saw_d;
  logic                  bad_q, bad_d;
  logic                  crp_q, crp_d;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_data_q, out_data_d;
  kind_e                 out_kind_q, out_kind_d;

  logic                  res_valid;
  kind_e                 res_kind;

  logic [MAX_BODY_W:0]   max_p1;
  logic                  over_lim;
  logic                  over_cap;
  logic                  top_busy;
  logic [COUNT_BITS-1:0] left_dec;
  logic                  crlf_seen;
  logic                  lone_cr;
  logic                  bad_mid;
  logic                  saw_mid;

  assign pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    max_p1    = {1'b0, max_body_i} + (MAX_BODY_W+1)'(1);
    over_lim  = CW'(chunk_q) > CW'(max_p1 >> 4);
    over_cap  = (CW'(total_q) + CW'(chunk_q)) > CW'(max_body_i);
    top_busy  = chunk_q[COUNT_BITS-1 -: 4] != 4'd0;
    left_dec  = left_q - COUNT_BITS'(1);
    crlf_seen = crp_q & item_i.is_lf;
    lone_cr   = crp_q & ~item_i.is_lf;
    bad_mid   = bad_q | (lone_cr & (phase_q == PH_SIZE));
    saw_mid   = saw_q | (lone_cr & (phase_q == PH_TRAILER));
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    chunk_d = chunk_q;
    left_d  = left_q;
    total_d = total_q;
    saw_d   = saw_q;
    bad_d   = bad_q;
    crp_d   = crp_q;
    if (pop_o) begin
      if (item_i.eos) begin
        phase_d = PH_SIZE;
        chunk_d = '0;
        left_d  = '0;
        total_d = '0;
        saw_d   = 1'b0;
        bad_d   = 1'b0;
        crp_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_DATA: begin
            left_d  = left_dec;
            total_d = total_q + COUNT_BITS'(1);
            if (left_dec == '0) begin
              phase_d = PH_DCR;
            end
          end
          PH_DCR: begin
            bad_d   = ~item_i.is_cr;
            phase_d = PH_DLF;
          end
          PH_DLF: begin
            if (bad_q || !item_i.is_lf) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_SIZE;
              chunk_d = '0;
              saw_d   = 1'b0;
              bad_d   = 1'b0;
              crp_d   = 1'b0;
            end
          end
          PH_SIZE, PH_EXT, PH_TRAILER: begin
            if (crlf_seen) begin
              crp_d = 1'b0;
              if (phase_q == PH_TRAILER) begin
                if (!saw_q) begin
                  phase_d = PH_DONE;
                end else begin
                  saw_d = 1'b0;
                end
              end else if (bad_q || !saw_q) begin
                phase_d = PH_DONE;
              end else if (chunk_q == '0) begin
                phase_d = PH_TRAILER;
                saw_d   = 1'b0;
              end else if (over_cap) begin
                phase_d = PH_DONE;
              end else begin
                left_d  = chunk_q;
                phase_d = PH_DATA;
              end
            end else begin
              saw_d = saw_mid;
              bad_d = bad_mid;
              crp_d = item_i.is_cr;
              if (!item_i.is_cr) begin
                if (phase_q == PH_TRAILER) begin
                  saw_d = 1'b1;
                end else if (phase_q == PH_SIZE) begin
                  if (item_i.is_semi) begin
                    phase_d = PH_EXT;
                  end else if (!item_i.is_hex) begin
                    bad_d = 1'b1;
                  end else if (!bad_mid) begin
                    if (over_lim || top_busy) begin
                      bad_d = 1'b1;
                    end else begin
                      chunk_d = {chunk_q[COUNT_BITS-5:0], item_i.hex_val};
                      saw_d   = 1'b1;
                    end
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result of the word being taken
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    if (item_i.eos) begin
      res_valid = (phase_q != PH_DONE);
      res_kind  = KIND_TRUNCATED;
    end else begin
      case (phase_q)
        PH_DATA: begin
          res_valid = 1'b1;
        end
        PH_DLF: begin
          res_valid = bad_q | ~item_i.is_lf;
          res_kind  = KIND_MALFORMED;
        end
        PH_SIZE, PH_EXT: begin
          res_valid = crlf_seen & (bad_q | ~saw_q | ((chunk_q != '0) & over_cap));
          res_kind  = KIND_MALFORMED;
        end
        PH_TRAILER: begin
          res_valid = crlf_seen & ~saw_q;
          res_kind  = KIND_COMPLETE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    if (pop_o) begin
      out_valid_d = res_valid;
      out_data_d  = (res_kind == KIND_PAYLOAD) ? item_i.data : 8'd0;
      out_kind_d  = res_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      chunk_q     <= '0;
      left_q      <= '0;
      total_q     <= '0;
      saw_q       <= 1'b0;
      bad_q       <= 1'b0;
      crp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      chunk_q     <= chunk_d;
      left_q      <= left_d;
      total_q     <= total_d;
      saw_q       <= saw_d;
      bad_q       <= bad_d;
      crp_q       <= crp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign out_kind_o        = out_kind_q;
  assign status_o.rearmed  = (phase_q == PH_SIZE) && (total_q == '0) && !crp_q;
  assign status_o.finished = (phase_q == PH_DONE);

endmodule

`default_nettype wire

[rtl/http_chunked_body_decoder_top.sv]
// an accepted word is held in chbd_queue; its result, if any, is registered in chbd_back
// throughput: one body word per cycle while the output register is free or being taken
// the two-entry queue absorbs input words while the output word waits; ready drops when full
// reset: rst_ni asynchronous active low; decoder at start of size line, max_body 1048576
// depends on chbd_pkg, chbd_front, chbd_queue, chbd_back
`default_nettype none

module http_chunked_body_decoder_top
  import chbd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned Q_DEPTH    = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_wr_en_i,
  input  wire logic [MAX_BODY_W-1:0] cfg_wr_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // data_byte
  input  wire logic                  s_axis_tuser,   // end_of_stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // payload_byte
  output logic [1:0]                 m_axis_tuser    // kind
);

  logic [MAX_BODY_W-1:0]        max_body_q;
  logic                         q_full;
  logic                         push;
  item_t                        push_item;
  logic                         q_valid;
  item_t                        head_item;
  logic                         pop;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;
  status_t                      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MAX_BODY_RESET;
    end else if (cfg_wr_en_i) begin
      max_body_q <= cfg_wr_data_i;
    end
  end

  chbd_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_eos_i   (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (push_item)
  );

  chbd_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item),
    .count_o (q_count)
  );

  chbd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_body_i  (max_body_q),
    .q_valid_i   (q_valid),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_ready_i (m_axis_tready),
    .status_o    (status)
  );

`ifndef SYNTH
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD)) |-> (m_axis_tdata == 8'd0))
    else $error("status word carries nonzero data");

  a_eos_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_item.eos) |=> status.rearmed)
    else $error("end of stream did not rearm decoder");

  a_done_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && status.finished && !head_item.eos) |=> !m_axis_tvalid)
    else $error("result after final answer");
`endif

endmodule

`default_nettype wire

[bench/http_chunked_body_decoder_top_test.sv]
// testbench for http_chunked_body_decoder_top: raw body words in, decoded words checked in order
// keeps its own chunked-decode predictor and sweeps max_body; needs chbd_pkg and the block rtl
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_test;
  import chbd_pkg::*;

  typedef logic [7:0] octet_t;

  typedef struct {
    octet_t data;
    logic   eos;
  } in_word_t;

  typedef struct {
    octet_t payload;
    kind_e  kind;
  } out_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_wr_en_i = 1'b0;
  logic [MAX_BODY_W-1:0] cfg_wr_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  http_chunked_body_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_word_t  in_words[$];
  out_word_t decoded_q[$];
  int        mismatch_cnt = 0;

  // predictor state
  logic [MAX_BODY_W-1:0] max_body_m = MAX_BODY_RESET;
  phase_e                ph = PH_SIZE;
  logic [23:0]           size_acc = '0;
  logic [23:0]           left_cnt = '0;
  logic [23:0]           total_cnt = '0;
  logic                  had_digit = 1'b0;
  logic                  bad_line = 1'b0;
  logic                  cr_wait = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic rearm_decoder();
    ph = PH_SIZE;
    size_acc = '0;
    left_cnt = '0;
    total_cnt = '0;
    had_digit = 1'b0;
    bad_line = 1'b0;
    cr_wait = 1'b0;
  endtask

  function automatic int hex_of(input octet_t c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic take_line_byte(input octet_t c);
    int          d;
    logic [24:0] lim;
    logic [27:0] nxt;
    if (ph == PH_TRAILER) begin
      had_digit = 1'b1;
      return;
    end
    if (ph != PH_SIZE) return;
    if (c == CHAR_SEMI) begin
      ph = PH_EXT;
      return;
    end
    d = hex_of(c);
    if (d < 0) begin
      bad_line = 1'b1;
      return;
    end
    if (bad_line) return;
    lim = ({1'b0, max_body_m} + 25'd1) >> 4;
    if ({1'b0, size_acc} > lim) begin
      bad_line = 1'b1;
      return;
    end
    nxt = {size_acc, 4'h0} + 28'(d);
    if (nxt > 28'hFFFFFF) begin
      bad_line = 1'b1;
      return;
    end
    size_acc = nxt[23:0];
    had_digit = 1'b1;
  endtask

  task automatic end_line(output logic hit, output kind_e k);
    hit = 1'b0;
    k = KIND_PAYLOAD;
    cr_wait = 1'b0;
    if (ph == PH_TRAILER) begin
      if (!had_digit) begin
        ph = PH_DONE;
        hit = 1'b1;
        k = KIND_COMPLETE;
      end else begin
        had_digit = 1'b0;
      end
    end else if (bad_line || !had_digit) begin
      ph = PH_DONE;
      hit = 1'b1;
      k = KIND_MALFORMED;
    end else if (size_acc == '0) begin
      ph = PH_TRAILER;
      had_digit = 1'b0;
    end else if ({1'b0, total_cnt} + {1'b0, size_acc} > {1'b0, max_body_m}) begin
      ph = PH_DONE;
      hit = 1'b1;
      k = KIND_MALFORMED;
    end else begin
      left_cnt = size_acc;
      ph = PH_DATA;
    end
  endtask

  // one accepted input word through the predictor; queues the word it should produce
  task automatic chunk_decode(input octet_t b, input logic eos);
    logic   hit;
    logic   ended;
    kind_e  k;
    octet_t pay;
    hit = 1'b0;
    ended = 1'b0;
    k = KIND_PAYLOAD;
    pay = 8'h00;
    if (eos) begin
      if (ph != PH_DONE) begin
        hit = 1'b1;
        k = KIND_TRUNCATED;
      end
      rearm_decoder();
    end else begin
      case (ph)
        PH_DATA: begin
          hit = 1'b1;
          pay = b;
          left_cnt = left_cnt - 24'd1;
          total_cnt = total_cnt + 24'd1;
          if (left_cnt == '0) ph = PH_DCR;
        end
        PH_DCR: begin
          bad_line = (b != CHAR_CR);
          ph = PH_DLF;
        end
        PH_DLF: begin
          if (bad_line || b != CHAR_LF) begin
            ph = PH_DONE;
            hit = 1'b1;
            k = KIND_MALFORMED;
          end else begin
            ph = PH_SIZE;
            size_acc = '0;
            had_digit = 1'b0;
            bad_line = 1'b0;
            cr_wait = 1'b0;
          end
        end
        PH_SIZE, PH_EXT, PH_TRAILER: begin
          if (cr_wait) begin
            if (b == CHAR_LF) begin
              end_line(hit, k);
              ended = 1'b1;
            end else begin
              cr_wait = 1'b0;
              take_line_byte(CHAR_CR);
            end
          end
          if (!ended) begin
            if (b == CHAR_CR) cr_wait = 1'b1;
            else take_line_byte(b);
          end
        end
        default: ;
      endcase
    end
    if (hit) decoded_q.push_back('{pay, k});
  endtask

  // sender: bursts and gaps, fed from in_words
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        chunk_decode(s_axis_tdata, s_axis_tuser);
        void'(in_words.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || in_words.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= in_words[0].data;
          s_axis_tuser <= in_words[0].eos;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern, renewed when its countdown runs out
  logic [15:0] sink_pat = 16'hFFFF;
  int          pat_left = 0;

  always @(posedge clk_i) begin : sink_ctl
    logic [15:0] fresh;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pat_left <= 0;
    end else begin
      if (pat_left == 0) begin
        pat_left <= 31;
        fresh = 16'($urandom);
        if ($urandom_range(0, 3) == 0) sink_pat <= 16'hFFFF;
        else sink_pat <= (fresh == '0) ? 16'h0001 : fresh;
      end else begin
        pat_left <= pat_left - 1;
        sink_pat <= {sink_pat[0], sink_pat[15:1]};
      end
      m_axis_tready <= sink_pat[0];
    end
  end

  always @(posedge clk_i) begin : out_check
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d data %02h", m_axis_tuser,
                                m_axis_tdata));
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tuser !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata !== want.payload)
          flag_mismatch($sformatf("payload %02h, want %02h", m_axis_tdata, want.payload));
      end
    end
  end

  task automatic push_word(input octet_t b, input logic eos);
    in_words.push_back('{b, eos});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(octet_t'(s[i]), 1'b0);
  endtask

  task automatic push_crlf();
    push_word(CHAR_CR, 1'b0);
    push_word(CHAR_LF, 1'b0);
  endtask

  function automatic octet_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return octet_t'("0") + octet_t'(nib);
    if ($urandom_range(0, 1) == 1) return octet_t'("a") + octet_t'(nib) - 8'd10;
    return octet_t'("A") + octet_t'(nib) - 8'd10;
  endfunction

  task automatic add_hex(ref octet_t q[$], input logic [27:0] v, input int pad);
    int n;
    n = 1;
    while (n < 7 && (v >> (4 * n)) != 0) n++;
    n += pad;
    for (int i = n - 1; i >= 0; i--) q.push_back(hex_char(4'(v >> (4 * i))));
  endtask

  task automatic add_text(ref octet_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(octet_t'(s[i]));
  endtask

  task automatic add_crlf(ref octet_t q[$]);
    q.push_back(CHAR_CR);
    q.push_back(CHAR_LF);
  endtask

  task automatic add_ext(ref octet_t q[$]);
    if ($urandom_range(0, 4) == 0) begin
      add_text(q, ";x=");
      if ($urandom_range(0, 1) == 1) q.push_back(CHAR_CR);
      add_text(q, "y");
    end
  endtask

  // a well-formed chunked body with random sizes, extensions, payload and trailers
  task automatic build_body(ref octet_t q[$]);
    int nchunks;
    int sz;
    int pad;
    nchunks = $urandom_range(0, 3);
    repeat (nchunks) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      add_hex(q, 28'(sz), pad);
      add_ext(q);
      add_crlf(q);
      repeat (sz) q.push_back(octet_t'($urandom));
      add_crlf(q);
    end
    add_hex(q, 28'd0, $urandom_range(0, 1));
    add_ext(q);
    add_crlf(q);
    repeat ($urandom_range(0, 2)) begin
      add_text(q, "X-T: v");
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(CHAR_CR);
        add_text(q, "w");
      end
      add_crlf(q);
    end
    add_crlf(q);
  endtask

  task automatic fill_random(input int target);
    octet_t body[$];
    int     count;
    int     r;
    int     cut;
    int     pos;
    count = 0;
    while (count < target) begin
      body.delete();
      r = $urandom_range(0, 99);
      if (r < 82) begin
        build_body(body);
        if (r >= 60 && r < 70) begin
          cut = $urandom_range(1, body.size() - 1);
          while (body.size() > cut) void'(body.pop_back());
        end else if (r >= 70) begin
          pos = $urandom_range(0, body.size() - 1);
          body[pos] = octet_t'($urandom);
        end
      end else if (r < 90) begin
        repeat ($urandom_range(6, 9)) body.push_back(hex_char(4'($urandom)));
        add_crlf(body);
        repeat (3) body.push_back(octet_t'($urandom));
      end else if (r < 95) begin
        case ($urandom_range(0, 3))
          0: add_crlf(body);
          1: begin
            add_text(body, ";x");
            add_crlf(body);
          end
          2: begin
            body.push_back(CHAR_CR);
            add_crlf(body);
          end
          default: begin
            add_text(body, "1");
            body.push_back(CHAR_CR);
            add_text(body, "z");
            add_crlf(body);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 4))
            0: body.push_back(CHAR_CR);
            1: body.push_back(CHAR_LF);
            2: body.push_back(CHAR_SEMI);
            3: body.push_back(hex_char(4'($urandom)));
            default: body.push_back(octet_t'($urandom));
          endcase
        end
      end
      count += body.size() + 1;
      foreach (body[i]) push_word(body[i], 1'b0);
      // bytes after a final answer are dropped by the block
      if (r < 60) repeat ($urandom_range(0, 3)) push_word(octet_t'($urandom), 1'b0);
      push_word(octet_t'($urandom), 1'b1);
    end
  endtask

  task automatic settle_and_set(input logic [MAX_BODY_W-1:0] v);
    while (in_words.size() != 0 || decoded_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    max_body_m = v;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [MAX_BODY_W-1:0] settings[5];
    settings[0] = '0;
    settings[1] = 24'hFFFFFF;
    settings[2] = 24'd40;
    settings[3] = 24'd7;
    settings[4] = MAX_BODY_W'($urandom_range(0, 300));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // stream end with nothing decoded
    push_word(8'h5A, 1'b1);
    // extension, zero payload byte, trailer with a lone cr, then ignored byte and silent rearm
    push_text("1;");
    push_crlf();
    push_word(8'h00, 1'b0);
    push_crlf();
    push_text("0");
    push_crlf();
    push_text("t");
    push_word(CHAR_CR, 1'b0);
    push_crlf();
    push_crlf();
    push_word(8'hFF, 1'b0);
    push_word(8'hA5, 1'b1);
    // bad chunk closing bytes
    push_text("1");
    push_crlf();
    push_word(8'hFF, 1'b0);
    push_text("x");
    push_word(CHAR_LF, 1'b0);
    push_word(8'h00, 1'b1);

    fill_random(185);
    foreach (settings[i]) begin
      settle_and_set(settings[i]);
      fill_random(185);
    end

    while (in_words.size() != 0 || decoded_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("http_chunked_body_decoder_top: match");
    end else begin
      $display("http_chunked_body_decoder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("http_chunked_body_decoder_top: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/chbd_pkg.sv
rtl/chbd_front.sv
rtl/chbd_queue.sv
rtl/chbd_back.sv
rtl/http_chunked_body_decoder_top.sv
bench/http_chunked_body_decoder_top_test.sv
